>>> rtl/core/gpf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid peak finder package
// Shared constants, command and status types for controller and datapath.
// ---------------------------------------------------------------------------
package gpf_pkg;

  localparam int GridSide     = 32;
  localparam int FractionBits = 8;
  localparam int PeakSlots    = 4;
  localparam int CellCount    = GridSide * GridSide;
  localparam int CoordW       = $clog2(GridSide);
  localparam int AddrW        = $clog2(CellCount);
  localparam int SlotW        = 2;
  localparam int AmpW         = 16;
  localparam int OrdW         = 7;
  localparam int PosW         = 15;
  localparam int DiffW        = AmpW + 1;
  localparam int NumW         = DiffW + FractionBits;
  localparam int QuotW        = NumW;
  localparam int DivCycles    = NumW;

  localparam logic [OrdW-1:0] UnusableOrder  = 7'd127;
  localparam logic [AmpW-1:0] ThresholdReset = 16'd600;

  // neighbour read order used by the controller
  typedef enum logic [3:0] {
    NB_CENTRE = 4'd0,
    NB_W      = 4'd1,
    NB_NW     = 4'd2,
    NB_N      = 4'd3,
    NB_NE     = 4'd4,
    NB_E      = 4'd5,
    NB_SE     = 4'd6,
    NB_S      = 4'd7,
    NB_SW     = 4'd8
  } nb_t;

  typedef struct packed {
    logic                load_cell;   // write input cell at load address
    logic                rd_en;       // issue a store read
    nb_t                 rd_nb;       // which neighbour of scan cell
    logic                cap_centre;  // capture centre read data
    logic                cap_nb;      // compare / capture neighbour data
    nb_t                 cap_which;
    logic                scan_clear;  // reset scan position and peak table
    logic                scan_next;   // advance scan position
    logic                keep_peak;   // store centre as peak
    logic                sel_slot;    // load refinement slot
    logic [SlotW-1:0]    slot;
    logic                div_start;
    logic                div_y;       // 0: x axis, 1: y axis
    logic                res_load;    // load output register
  } gpf_cmd_t;

  typedef struct packed {
    logic load_last;    // current load is last cell
    logic scan_last;    // scan at final cell
    logic centre_ok;    // centre usable, at or above threshold, slot free
    logic is_peak;      // no neighbour larger so far
    logic div_busy;
    logic nb_valid;     // addressed neighbour lies in grid
  } gpf_sts_t;

endpackage

>>> rtl/core/gpf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module gpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/gpf_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequential signed divider
// Restoring division, one quotient bit a cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module gpf_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [gpf_pkg::NumW-1:0]     num,
  input  logic [gpf_pkg::AmpW-1:0]            den,
  output logic                                busy,
  output logic signed [gpf_pkg::QuotW-1:0]    quot
);

  localparam int CntW = $clog2(gpf_pkg::DivCycles + 1);

  logic [gpf_pkg::NumW-1:0] mag;
  logic [gpf_pkg::AmpW:0]   rem;
  logic [gpf_pkg::AmpW-1:0] dvs;
  logic                     neg;
  logic [CntW-1:0]          cnt;
  logic [gpf_pkg::AmpW:0]   trial;
  logic [gpf_pkg::AmpW:0]   shifted;

  assign shifted = {rem[gpf_pkg::AmpW-1:0], mag[gpf_pkg::NumW-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= (den != '0);
      cnt  <= CntW'(gpf_pkg::DivCycles);
      neg  <= num[gpf_pkg::NumW-1];
      mag  <= num[gpf_pkg::NumW-1] ? gpf_pkg::NumW'(-num) : gpf_pkg::NumW'(num);
      rem  <= '0;
      dvs  <= den;
    end else if (busy) begin
      if (trial[gpf_pkg::AmpW]) begin
        rem <= shifted;
        mag <= {mag[gpf_pkg::NumW-2:0], 1'b0};
      end else begin
        rem <= trial;
        mag <= {mag[gpf_pkg::NumW-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // result is valid once busy falls; a zero divisor leaves it cleared
  logic signed [gpf_pkg::QuotW-1:0] quot_hold;
  always_ff @(posedge clk) begin
    if (busy && cnt == CntW'(1)) begin
      quot_hold <= neg ? -gpf_pkg::QuotW'({mag[gpf_pkg::NumW-2:0], ~trial[gpf_pkg::AmpW]})
                       :  gpf_pkg::QuotW'({mag[gpf_pkg::NumW-2:0], ~trial[gpf_pkg::AmpW]});
    end else if (start) begin
      quot_hold <= '0;
    end
  end

  assign quot = quot_hold;

endmodule

>>> rtl/core/gpf_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid peak finder datapath
// Cell stores, scan position, neighbour compare, peak table and refinement.
// ---------------------------------------------------------------------------
module gpf_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  gpf_pkg::gpf_cmd_t               cmd,
  output gpf_pkg::gpf_sts_t               sts,
  input  logic [gpf_pkg::AmpW-1:0]        threshold,
  input  logic [gpf_pkg::AmpW-1:0]        in_amp,
  input  logic [gpf_pkg::OrdW-1:0]        in_ord,
  output logic [gpf_pkg::SlotW-1:0]       r_slot,
  output logic                            r_valid,
  output logic [gpf_pkg::AmpW-1:0]        r_amp,
  output logic [gpf_pkg::OrdW-1:0]        r_ord,
  output logic signed [gpf_pkg::PosW-1:0] r_x,
  output logic signed [gpf_pkg::PosW-1:0] r_y
);

  localparam int CW = gpf_pkg::CoordW;
  localparam int AW = gpf_pkg::AmpW;

  logic [gpf_pkg::AddrW-1:0] load_addr;
  logic [CW-1:0]             sx, sy;
  logic [2:0]                peak_count;
  logic [AW-1:0]             centre_amp;
  logic [gpf_pkg::OrdW-1:0]  centre_ord;
  logic                      peak_ok;
  logic [AW-1:0]             mem_amp;
  logic [gpf_pkg::OrdW-1:0]  mem_ord;

  logic [AW-1:0]             t_amp [gpf_pkg::PeakSlots];
  logic [gpf_pkg::OrdW-1:0]  t_ord [gpf_pkg::PeakSlots];
  logic [CW-1:0]             t_x   [gpf_pkg::PeakSlots];
  logic [CW-1:0]             t_y   [gpf_pkg::PeakSlots];
  logic [AW-1:0]             t_l   [gpf_pkg::PeakSlots];
  logic [AW-1:0]             t_r   [gpf_pkg::PeakSlots];
  logic [AW-1:0]             t_u   [gpf_pkg::PeakSlots];
  logic [AW-1:0]             t_d   [gpf_pkg::PeakSlots];
  logic [AW-1:0]             nb_l, nb_r, nb_u, nb_d;

  // neighbour offsets
  logic signed [CW+1:0] nx, ny;
  logic                 nb_in;
  logic                 cap_in;
  logic signed [CW+1:0] cx_off, cy_off;

  function automatic logic signed [1:0] dx_of(gpf_pkg::nb_t n);
    case (n)
      gpf_pkg::NB_W, gpf_pkg::NB_NW, gpf_pkg::NB_SW: dx_of = -2'sd1;
      gpf_pkg::NB_E, gpf_pkg::NB_NE, gpf_pkg::NB_SE: dx_of = 2'sd1;
      default:                                       dx_of = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dy_of(gpf_pkg::nb_t n);
    case (n)
      gpf_pkg::NB_N, gpf_pkg::NB_NW, gpf_pkg::NB_NE: dy_of = -2'sd1;
      gpf_pkg::NB_S, gpf_pkg::NB_SW, gpf_pkg::NB_SE: dy_of = 2'sd1;
      default:                                       dy_of = 2'sd0;
    endcase
  endfunction

  assign nx = $signed({2'b00, sx}) + (CW+2)'(dx_of(cmd.rd_nb));
  assign ny = $signed({2'b00, sy}) + (CW+2)'(dy_of(cmd.rd_nb));
  assign nb_in = (nx >= 0) && (nx < gpf_pkg::GridSide)
              && (ny >= 0) && (ny < gpf_pkg::GridSide);

  assign cx_off = $signed({2'b00, sx}) + (CW+2)'(dx_of(cmd.cap_which));
  assign cy_off = $signed({2'b00, sy}) + (CW+2)'(dy_of(cmd.cap_which));
  assign cap_in = (cx_off >= 0) && (cx_off < gpf_pkg::GridSide)
               && (cy_off >= 0) && (cy_off < gpf_pkg::GridSide);

  // refinement slot; its neighbours were kept with the peak
  logic [gpf_pkg::SlotW-1:0] rslot;
  logic [gpf_pkg::AddrW-1:0] raddr;
  assign raddr = {ny[CW-1:0], nx[CW-1:0]};

  gpf_ram #(.Width(AW), .Depth(gpf_pkg::CellCount)) u_amp_ram (
    .clk(clk), .we(cmd.load_cell), .waddr(load_addr), .wdata(in_amp),
    .re(cmd.rd_en), .raddr(raddr), .rdata(mem_amp));

  gpf_ram #(.Width(gpf_pkg::OrdW), .Depth(gpf_pkg::CellCount)) u_ord_ram (
    .clk(clk), .we(cmd.load_cell), .waddr(load_addr), .wdata(in_ord),
    .re(cmd.rd_en), .raddr(raddr), .rdata(mem_ord));

  always_ff @(posedge clk) begin
    if (rst) begin
      load_addr  <= '0;
      peak_count <= '0;
      sx         <= '0;
      sy         <= '0;
      peak_ok    <= 1'b0;
    end else begin
      if (cmd.load_cell) begin
        load_addr <= load_addr + 1'b1;
      end
      if (cmd.scan_clear) begin
        sx         <= '0;
        sy         <= '0;
        peak_count <= '0;
      end else if (cmd.scan_next) begin
        if (sy == CW'(gpf_pkg::GridSide - 1)) begin
          sy <= '0;
          sx <= sx + 1'b1;
        end else begin
          sy <= sy + 1'b1;
        end
      end
      if (cmd.cap_centre) begin
        peak_ok <= 1'b1;
      end else if (cmd.cap_nb && cap_in && mem_amp > centre_amp) begin
        peak_ok <= 1'b0;
      end
      if (cmd.keep_peak) begin
        peak_count <= peak_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_centre) begin
      centre_amp <= mem_amp;
      centre_ord <= mem_ord;
    end
    if (cmd.keep_peak) begin
      t_amp[peak_count[gpf_pkg::SlotW-1:0]] <= centre_amp;
      t_ord[peak_count[gpf_pkg::SlotW-1:0]] <= centre_ord;
      t_x[peak_count[gpf_pkg::SlotW-1:0]]   <= sx;
      t_y[peak_count[gpf_pkg::SlotW-1:0]]   <= sy;
      t_l[peak_count[gpf_pkg::SlotW-1:0]]   <= nb_l;
      t_r[peak_count[gpf_pkg::SlotW-1:0]]   <= nb_r;
      t_u[peak_count[gpf_pkg::SlotW-1:0]]   <= nb_u;
      t_d[peak_count[gpf_pkg::SlotW-1:0]]   <= nb_d;
    end
    if (cmd.sel_slot) begin
      rslot <= cmd.slot;
    end
    // neighbour amplitudes for refinement, zero off-grid
    if (cmd.cap_nb) begin
      case (cmd.cap_which)
        gpf_pkg::NB_W: nb_l <= cap_in ? mem_amp : '0;
        gpf_pkg::NB_E: nb_r <= cap_in ? mem_amp : '0;
        gpf_pkg::NB_N: nb_u <= cap_in ? mem_amp : '0;
        gpf_pkg::NB_S: nb_d <= cap_in ? mem_amp : '0;
        default: ;
      endcase
    end
  end

  assign sts.load_last = (load_addr == gpf_pkg::AddrW'(gpf_pkg::CellCount - 1));
  assign sts.scan_last = (sx == CW'(gpf_pkg::GridSide - 1))
                      && (sy == CW'(gpf_pkg::GridSide - 1));
  assign sts.centre_ok = (centre_ord != gpf_pkg::UnusableOrder)
                      && (centre_amp >= threshold)
                      && (peak_count < 3'(gpf_pkg::PeakSlots));
  assign sts.is_peak   = peak_ok;
  assign sts.nb_valid  = nb_in;

  // refinement: divide (plus - minus) << FractionBits by amplitude
  logic signed [gpf_pkg::NumW-1:0]  num;
  logic signed [gpf_pkg::QuotW-1:0] quot;
  logic signed [gpf_pkg::DiffW-1:0] diff;
  logic                             div_busy;
  logic                             slot_full;
  logic [AW-1:0]                    den;

  assign slot_full = (3'(rslot) < peak_count);
  // an empty slot divides by zero, which the divider skips
  assign den  = slot_full ? t_amp[rslot] : '0;
  assign diff = cmd.div_y ? ($signed({1'b0, t_d[rslot]}) - $signed({1'b0, t_u[rslot]}))
                          : ($signed({1'b0, t_r[rslot]}) - $signed({1'b0, t_l[rslot]}));
  assign num  = {diff, {gpf_pkg::FractionBits{1'b0}}};

  gpf_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num),
    .den(den), .busy(div_busy), .quot(quot));

  assign sts.div_busy = div_busy;

  logic signed [gpf_pkg::PosW-1:0] x_hold;
  logic signed [gpf_pkg::PosW-1:0] base_x, base_y;

  assign base_x = gpf_pkg::PosW'({t_x[rslot], {gpf_pkg::FractionBits{1'b0}}});
  assign base_y = gpf_pkg::PosW'({t_y[rslot], {gpf_pkg::FractionBits{1'b0}}});

  always_ff @(posedge clk) begin
    // x offset is kept while the y division runs
    if (cmd.div_start && cmd.div_y) begin
      x_hold <= base_x + gpf_pkg::PosW'(quot);
    end
    if (cmd.res_load) begin
      r_slot  <= rslot;
      r_valid <= slot_full;
      r_amp   <= slot_full ? t_amp[rslot] : '0;
      r_ord   <= slot_full ? t_ord[rslot] : '0;
      r_x     <= slot_full ? x_hold : '0;
      r_y     <= slot_full ? base_y + gpf_pkg::PosW'(quot) : '0;
    end
  end

endmodule

>>> rtl/core/gpf_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid peak finder controller
// Sequences load, window scan, slot refinement and result hand-off.
// ---------------------------------------------------------------------------
module gpf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_last,
  output gpf_pkg::gpf_cmd_t         cmd,
  input  gpf_pkg::gpf_sts_t         sts
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_CENTRE,
    S_CAP_CENTRE,
    S_WINDOW,
    S_DECIDE,
    S_SLOT,
    S_RD_REF,
    S_DIV_X,
    S_DIV_Y,
    S_RESULT,
    S_EMIT
  } state_t;

  state_t                    state;
  gpf_pkg::nb_t              nb;        // neighbour being read
  gpf_pkg::nb_t              nb_cap;    // neighbour data arriving
  logic                      cap_pend;
  logic [gpf_pkg::SlotW-1:0] slot;
  logic                      div_wait;

  logic accept_in;
  assign accept_in = (state == S_LOAD) && in_valid;
  assign in_stall  = (state != S_LOAD);

  always_comb begin
    cmd            = '0;
    cmd.load_cell  = accept_in;
    cmd.scan_clear = accept_in && sts.load_last;
    cmd.rd_nb      = nb;
    cmd.cap_which  = nb_cap;
    cmd.cap_nb     = cap_pend;
    cmd.slot       = slot;
    case (state)
      S_RD_CENTRE: begin
        cmd.rd_en = 1'b1;
      end
      S_CAP_CENTRE: cmd.cap_centre = 1'b1;
      S_WINDOW:     cmd.rd_en = (nb != gpf_pkg::NB_CENTRE) && sts.nb_valid;
      S_DECIDE: begin
        cmd.keep_peak = sts.centre_ok && sts.is_peak;
        cmd.scan_next = 1'b1;
      end
      S_SLOT:       cmd.sel_slot = 1'b1;
      S_DIV_X:      cmd.div_start = !div_wait;
      S_DIV_Y: begin
        cmd.div_start = !div_wait;
        cmd.div_y     = 1'b1;
      end
      S_RESULT: begin
        cmd.res_load = !sts.div_busy && div_wait;
        cmd.div_y    = 1'b1;
      end
      default: ;
    endcase
    if (state == S_DIV_Y && !div_wait) begin
      cmd.div_y = 1'b1;
    end
  end

  // the neighbour read sequence walks W, NW, N, NE, E, SE, S, SW
  function automatic gpf_pkg::nb_t nb_succ(gpf_pkg::nb_t n);
    case (n)
      gpf_pkg::NB_CENTRE: nb_succ = gpf_pkg::NB_W;
      gpf_pkg::NB_W:      nb_succ = gpf_pkg::NB_NW;
      gpf_pkg::NB_NW:     nb_succ = gpf_pkg::NB_N;
      gpf_pkg::NB_N:      nb_succ = gpf_pkg::NB_NE;
      gpf_pkg::NB_NE:     nb_succ = gpf_pkg::NB_E;
      gpf_pkg::NB_E:      nb_succ = gpf_pkg::NB_SE;
      gpf_pkg::NB_SE:     nb_succ = gpf_pkg::NB_S;
      gpf_pkg::NB_S:      nb_succ = gpf_pkg::NB_SW;
      default:            nb_succ = gpf_pkg::NB_CENTRE;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      nb        <= gpf_pkg::NB_CENTRE;
      nb_cap    <= gpf_pkg::NB_CENTRE;
      cap_pend  <= 1'b0;
      slot      <= '0;
      div_wait  <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      cap_pend <= 1'b0;
      case (state)
        S_LOAD: begin
          if (accept_in && sts.load_last) begin
            state <= S_RD_CENTRE;
          end
        end
        S_RD_CENTRE: begin
          nb    <= gpf_pkg::NB_W;
          state <= S_CAP_CENTRE;
        end
        S_CAP_CENTRE: state <= S_WINDOW;
        S_WINDOW: begin
          // in scan mode a skipped off-grid read leaves its compare masked
          cap_pend <= (nb != gpf_pkg::NB_CENTRE);
          nb_cap   <= nb;
          if (nb == gpf_pkg::NB_CENTRE) begin
            state <= S_DECIDE;
          end else begin
            nb <= nb_succ(nb);
          end
        end
        S_DECIDE: begin
          if (sts.scan_last) begin
            slot  <= '0;
            state <= S_SLOT;
          end else begin
            state <= S_RD_CENTRE;
          end
        end
        S_SLOT: begin
          state <= S_RD_REF;
        end
        S_RD_REF: begin
          state <= S_DIV_X;
        end
        S_DIV_X: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
          end else if (!sts.div_busy) begin
            div_wait <= 1'b0;
            state    <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            state    <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!sts.div_busy) begin
            div_wait  <= 1'b0;
            out_valid <= 1'b1;
            out_last  <= (slot == gpf_pkg::SlotW'(gpf_pkg::PeakSlots - 1));
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            out_last  <= 1'b0;
            if (slot == gpf_pkg::SlotW'(gpf_pkg::PeakSlots - 1)) begin
              state <= S_LOAD;
            end else begin
              slot  <= slot + 1'b1;
              state <= S_SLOT;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

>>> rtl/core/grid_peak_finder_subcell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid peak finder with sub-cell refinement
// Top level: threshold register, controller and datapath.
// ---------------------------------------------------------------------------
// Input channel: one request per grid cell (amplitude, order), x fastest.
// While loading, every offered cell is taken; 1024 requests form a frame.
// After the last cell the block stalls its input, scans every cell through a
// 9-cell window on the single read port of the cell store, then refines each
// of the 4 slots with two serial divisions (none for an empty slot) and offers
// one result per slot, last_slot marking the fourth. A stalled result holds
// until taken; the next slot and further loading wait for it.
// The user must write amplitude_threshold by threshold_we only while the block
// is idle; the block itself does not enforce it. Reset clears the controller,
// the counters and sets the threshold to 600; the cell stores are not cleared,
// as every cell is written before a scan.
// ---------------------------------------------------------------------------
module grid_peak_finder_subcell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  threshold_we,
  input  logic [gpf_pkg::AmpW-1:0]              threshold_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [gpf_pkg::AmpW-1:0]              cell_amplitude,
  input  logic [gpf_pkg::OrdW-1:0]              cell_order,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [gpf_pkg::SlotW-1:0]             slot_index,
  output logic                                  peak_valid,
  output logic [gpf_pkg::AmpW-1:0]              peak_amplitude,
  output logic [gpf_pkg::OrdW-1:0]              peak_order,
  output logic signed [gpf_pkg::PosW-1:0]       x_position,
  output logic signed [gpf_pkg::PosW-1:0]       y_position,
  output logic                                  last_slot
);

  logic [gpf_pkg::AmpW-1:0] threshold;
  gpf_pkg::gpf_cmd_t        cmd;
  gpf_pkg::gpf_sts_t        sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gpf_pkg::ThresholdReset;
    end else if (threshold_we) begin
      threshold <= threshold_wdata;
    end
  end

  gpf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_last(last_slot),
    .cmd(cmd), .sts(sts));

  gpf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .threshold(threshold),
    .in_amp(cell_amplitude), .in_ord(cell_order),
    .r_slot(slot_index), .r_valid(peak_valid), .r_amp(peak_amplitude),
    .r_ord(peak_order), .r_x(x_position), .r_y(y_position));

endmodule

>>> rtl/core/gpf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid peak finder checker
// Port-level properties of the result stream, bound to the top level.
// ---------------------------------------------------------------------------
module gpf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [gpf_pkg::SlotW-1:0]   slot_index,
  input logic                        peak_valid,
  input logic [gpf_pkg::AmpW-1:0]    peak_amplitude,
  input logic                        last_slot
);

  // no request taken while results are offered
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during result");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_slot == (slot_index == gpf_pkg::SlotW'(gpf_pkg::PeakSlots - 1))))
    else $error("last_slot mismatch");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !peak_valid |-> peak_amplitude == '0)
    else $error("empty slot not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(slot_index))
    else $error("stalled result changed");

endmodule

bind grid_peak_finder_subcell gpf_checker u_gpf_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .slot_index(slot_index), .peak_valid(peak_valid),
  .peak_amplitude(peak_amplitude), .last_slot(last_slot));
